// ===== rtl/rgr_pkg.sv =====
// shared widths, defaults and codes of the rgb gradient resampler
package rgr_pkg;

    localparam int MAX_SRC_DEF   = 64;
    localparam int MAX_OUT_DEF   = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int LEN_W     = 7;
    localparam int STEP_W    = 24;
    localparam int POS_W     = LEN_W + STEP_W;
    localparam int COLOR_W   = 8;
    localparam int RGB_W     = 3 * COLOR_W;
    localparam int IDX_W     = 6;
    localparam int TDATA_W   = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [STEP_W-1:0] POS_STEP_RST = STEP_W'(65536);

    localparam logic [1:0] REG_SRC_LEN  = 2'd0;
    localparam logic [1:0] REG_OUT_LEN  = 2'd1;
    localparam logic [1:0] REG_POS_STEP = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_GEN  = 1'b1;

endpackage

// ===== rtl/rgb_gradient_resampler.sv =====
// Streams linearly interpolated RGB colours out of a loaded source palette.
// A load transaction (tuser low) writes one colour into the palette memory. A generate
// transaction (tuser high) issues one pair of palette reads per cycle while the output is not
// stalled, out_len pairs in all (at most MAX_OUT), s_tready staying low until the last pair is
// issued; the colours leave through a read, multiply and add pipeline, one per cycle while
// m_tready is high, and a stalled output holds the whole pipeline. The palette is a single
// 24-bit memory with two read ports.
module rgb_gradient_resampler #(
    parameter int MAX_SRC   = rgr_pkg::MAX_SRC_DEF,
    parameter int MAX_OUT   = rgr_pkg::MAX_OUT_DEF,
    parameter int FRAC_BITS = rgr_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index, red_in, green_in, blue_in
    input  logic [rgr_pkg::TDATA_W-1:0]       s_tdata,
    // req_type
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_index, red_out, green_out, blue_out
    output logic [rgr_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rgr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rgr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rgr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import rgr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SRC);
    localparam int KW     = POS_W - FRAC_BITS;
    localparam int PROD_W = FRAC_BITS + 10;

    logic [LEN_W-1:0]  src_len_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [STEP_W-1:0] pos_step_reg;

    logic              cfg_wr;
    logic [1:0]        reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_len_reg  <= '0;
            out_len_reg  <= '0;
            pos_step_reg <= POS_STEP_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_SRC_LEN:  src_len_reg  <= pwdata[LEN_W-1:0];
                REG_OUT_LEN:  out_len_reg  <= pwdata[LEN_W-1:0];
                REG_POS_STEP: pos_step_reg <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SRC_LEN:  prdata = APB_DATA_W'(src_len_reg);
            REG_OUT_LEN:  prdata = APB_DATA_W'(out_len_reg);
            REG_POS_STEP: prdata = APB_DATA_W'(pos_step_reg);
            default:      prdata = '0;
        endcase
    end

    // issue control
    logic              gen_active_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [POS_W-1:0]  pos_reg;

    logic [LEN_W-1:0]  n_eff;
    logic [LEN_W-1:0]  count;
    logic [LEN_W-1:0]  last_idx;
    logic [LEN_W-1:0]  cnt_inc;
    logic [KW-1:0]     k_pos;
    logic              clamp;
    logic              issue_last;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic              s_acc;
    logic              adv;

    assign n_eff    = (32'(src_len_reg) > MAX_SRC) ? LEN_W'(MAX_SRC) : src_len_reg;
    assign count    = (32'(out_len_reg) > MAX_OUT) ? LEN_W'(MAX_OUT) : out_len_reg;
    assign last_idx = n_eff - LEN_W'(1);
    assign cnt_inc  = cnt_reg + LEN_W'(1);
    assign k_pos    = pos_reg[POS_W-1:FRAC_BITS];
    assign clamp    = k_pos >= KW'(last_idx);
    assign lo_addr  = clamp ? ADDR_W'(last_idx) : ADDR_W'(k_pos);
    assign hi_addr  = clamp ? ADDR_W'(last_idx) : ADDR_W'(k_pos) + ADDR_W'(1);
    assign issue_last = cnt_inc == count;

    assign s_tready = !gen_active_reg;
    assign s_acc    = s_tvalid & s_tready;

    // pipeline stages
    logic                 s1_valid_reg;
    logic [FRAC_BITS-1:0] s1_frac_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic                 s1_last_reg;
    logic                 s1_empty_reg;
    logic [RGB_W-1:0]     rd_lo_reg;
    logic [RGB_W-1:0]     rd_hi_reg;

    logic                     s2_valid_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic                     s2_last_reg;
    logic                     s2_empty_reg;
    logic [COLOR_W-1:0]       s2_lo_reg   [3];
    logic signed [PROD_W-1:0] s2_prod_reg [3];

    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_last_reg;
    logic [COLOR_W-1:0]   out_color_reg [3];

    assign adv = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_active_reg <= 1'b0;
        end else if (s_acc && s_tuser == REQ_GEN) begin
            gen_active_reg <= count != '0;
        end else if (gen_active_reg && adv && issue_last) begin
            gen_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end else if (gen_active_reg && adv) begin
            cnt_reg <= cnt_inc;
            pos_reg <= pos_reg + POS_W'(pos_step_reg);
        end
    end

    // palette memory: {blue, green, red}
    logic [RGB_W-1:0] palette_mem [MAX_SRC];

    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == REQ_LOAD && 32'(s_tdata[IDX_W-1:0]) < MAX_SRC) begin
            palette_mem[ADDR_W'(s_tdata[IDX_W-1:0])] <= s_tdata[IDX_W +: RGB_W];
        end
        if (adv && gen_active_reg) begin
            rd_lo_reg <= palette_mem[lo_addr];
            rd_hi_reg <= palette_mem[hi_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= gen_active_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    logic signed [8:0]        diff      [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] delta     [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c] = $signed({1'b0, rd_hi_reg[COLOR_W*c +: COLOR_W]})
                    - $signed({1'b0, rd_lo_reg[COLOR_W*c +: COLOR_W]});
            prod_next[c] = diff[c] * $signed({1'b0, s1_frac_reg});
            delta[c]     = s2_prod_reg[c] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_frac_reg  <= pos_reg[FRAC_BITS-1:0];
            s1_idx_reg   <= cnt_reg[IDX_W-1:0];
            s1_last_reg  <= issue_last;
            s1_empty_reg <= n_eff == '0;

            s2_idx_reg   <= s1_idx_reg;
            s2_last_reg  <= s1_last_reg;
            s2_empty_reg <= s1_empty_reg;

            out_idx_reg  <= s2_idx_reg;
            out_last_reg <= s2_last_reg;
            for (int c = 0; c < 3; c++) begin
                s2_lo_reg[c]     <= rd_lo_reg[COLOR_W*c +: COLOR_W];
                s2_prod_reg[c]   <= prod_next[c];
                out_color_reg[c] <= s2_empty_reg ? '0
                                  : s2_lo_reg[c] + delta[c][COLOR_W-1:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = TDATA_W'({out_color_reg[2], out_color_reg[1], out_color_reg[0],
                                out_idx_reg});

endmodule

// ===== rtl/rgr_checker.sv =====
// port-level checker of the rgb gradient resampler with its bind
module rgr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rgr_pkg::TDATA_W-1:0]    m_tdata,
    input logic                           m_tlast
);
    import rgr_pkg::*;

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // the input side closes only after a generate transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready && s_tuser == REQ_GEN))
        else $error("s_tready fell without a generate transaction");

    // reset empties the result pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind rgb_gradient_resampler rgr_checker u_rgr_checker (.*);
